[rtl/jsu_pkg.sv]
// Shared types, codes and character helpers for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned MAX_RES    = 3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_ESC = 2'd1;
	localparam logic [1:0] ST_BAD_HEX = 2'd2;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [15:0] UTF8_MAX1 = 16'h007F;
	localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	typedef enum logic [3:0] {
		M_NORMAL  = 4'b0001,
		M_ESCAPE  = 4'b0010,
		M_HEX     = 4'b0100,
		M_DISCARD = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [1:0] status;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t [MAX_RES-1:0] res;
	} group_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] data;
	} esc_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic esc_t escape_map(input logic [7:0] c);
		esc_t r;
		r.ok = 1'b1;
		case (c)
			8'h5C:   r.data = 8'h5C;
			8'h2F:   r.data = 8'h2F;
			8'h62:   r.data = 8'h08;
			8'h66:   r.data = 8'h0C;
			8'h6E:   r.data = 8'h0A;
			8'h72:   r.data = 8'h0D;
			8'h74:   r.data = 8'h09;
			8'h76:   r.data = 8'h0B;
			8'h27:   r.data = 8'h27;
			8'h22:   r.data = 8'h22;
			8'h00:   r.data = 8'h00;
			default: begin
				r.ok   = 1'b0;
				r.data = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		if (c inside {[8'h30:8'h39]}) begin
			r.nib = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r.nib = c[3:0] + 4'd9;
		end else begin
			r.ok  = 1'b0;
			r.nib = 4'd0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/json_string_unescape_utf8_core.sv]
// JSON string body unescaper with UTF-8 encoding of u-escapes (top level).
// Takes one string byte per cycle (in_valid/in_stall) into an input register, decodes it
// there into zero to three result bytes, and places them in a four-entry result queue
// that res_valid/res_stall drains at one result per cycle. A byte enters in every cycle
// while the queue can take three more results after this cycle's transfer out, so the
// sustained rate is one byte per cycle whenever bytes average at most one result each;
// u-escapes that expand to two or three UTF-8 bytes are paced by the output port.
// Errors give one result with out_valid low, out_status set and out_last high, and the
// rest of the string is dropped up to its last byte.
`default_nettype none
module json_string_unescape_utf8_core
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic [1:0]      out_status,
	output logic            out_last
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               take;
	logic               advance;
	logic               can_push;
	logic               pop;
	group_t             grp;
	result_t            head;
	logic [FIFO_AW:0]   level;

	assign advance  = valid_s1 && can_push;
	assign in_stall = valid_s1 && !can_push;
	assign take     = in_valid && !in_stall;
	assign pop      = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.grp     (grp)
	);

	jsu_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.grp       (grp),
		.pop       (pop),
		.head      (head),
		.not_empty (res_valid),
		.can_push  (can_push),
		.level     (level)
	);

	assign out_byte   = head.data;
	assign out_valid  = head.valid;
	assign out_status = head.status;
	assign out_last   = head.last;

	a_err_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_status != ST_OK) |-> (out_last && !out_valid))
		else $error("error result not marked final");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_byte == 8'h00 && out_last))
		else $error("marker result carries data or is not final");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register lost a stalled byte");

endmodule
`default_nettype wire

[rtl/jsu_decode.sv]
// Escape decoder: mode state, held u-digits and the per-byte result group.
`default_nettype none
module jsu_decode
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] byte_s1,
	input  wire logic       last_s1,
	output group_t          grp
);

	mode_t      mode_q, mode_d;
	logic [1:0] hc_q, hc_d;
	logic [7:0] held_q [0:2];
	logic       held_we;

	always_comb begin
		logic [1:0]  n;
		logic        err;
		logic [7:0]  t [0:2];
		logic [1:0]  len;
		logic        skip;
		logic        stop;
		logic [7:0]  e;
		esc_t        em;
		hex_t        h0, h1, h2, h3;
		logic [15:0] v;

		n       = 2'd0;
		err     = 1'b0;
		mode_d  = mode_q;
		hc_d    = hc_q;
		held_we = 1'b0;
		skip    = 1'b0;
		stop    = 1'b0;
		e       = 8'h00;
		em      = '0;
		grp     = '0;
		t[0]    = held_q[0];
		t[1]    = held_q[1];
		t[2]    = held_q[2];
		case (hc_q)
			2'd0:    t[0] = byte_s1;
			2'd1:    t[1] = byte_s1;
			default: t[2] = byte_s1;
		endcase
		len = hc_q + 2'd1;
		h0  = hex_value(held_q[0]);
		h1  = hex_value(held_q[1]);
		h2  = hex_value(held_q[2]);
		h3  = hex_value(byte_s1);
		v   = {h0.nib, h1.nib, h2.nib, h3.nib};

		case (mode_q)
			M_DISCARD: begin
				if (last_s1) begin
					mode_d = M_NORMAL;
					hc_d   = 2'd0;
				end
			end
			M_NORMAL: begin
				if (byte_s1 == CH_BSLASH) begin
					mode_d = M_ESCAPE;
				end else begin
					grp.res[n] = '{byte_s1, 1'b1, ST_OK, 1'b0};
					n = n + 2'd1;
				end
			end
			M_ESCAPE: begin
				if (byte_s1 == CH_U) begin
					mode_d = M_HEX;
					hc_d   = 2'd0;
				end else begin
					em = escape_map(byte_s1);
					if (!em.ok) begin
						grp.res[n] = '{8'h00, 1'b0, ST_BAD_ESC, 1'b1};
						n   = n + 2'd1;
						err = 1'b1;
					end else begin
						grp.res[n] = '{em.data, 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
					end
					mode_d = M_NORMAL;
				end
			end
			M_HEX: begin
				if (hc_q != 2'd3) begin
					held_we = 1'b1;
					hc_d    = hc_q + 2'd1;
					if (last_s1) begin
						for (int k = 0; k < 3; k++) begin
							if (k < int'(len) && !stop) begin
								if (skip) begin
									skip = 1'b0;
								end else if (t[k] != CH_BSLASH) begin
									grp.res[n] = '{t[k], 1'b1, ST_OK, 1'b0};
									n = n + 2'd1;
								end else if (k < 2 && k + 1 < int'(len)) begin
									e    = t[k+1];
									skip = 1'b1;
									if (e != CH_U) begin
										em = escape_map(e);
										if (!em.ok) begin
											grp.res[n] = '{8'h00, 1'b0, ST_BAD_ESC, 1'b1};
											n    = n + 2'd1;
											err  = 1'b1;
											stop = 1'b1;
										end else begin
											grp.res[n] = '{em.data, 1'b1, ST_OK, 1'b0};
											n = n + 2'd1;
										end
									end
								end
							end
						end
						mode_d = M_NORMAL;
						hc_d   = 2'd0;
					end
				end else begin
					if (!(h0.ok && h1.ok && h2.ok && h3.ok)) begin
						grp.res[n] = '{8'h00, 1'b0, ST_BAD_HEX, 1'b1};
						n   = n + 2'd1;
						err = 1'b1;
					end else if (v <= UTF8_MAX1) begin
						grp.res[n] = '{v[7:0], 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
					end else if (v <= UTF8_MAX2) begin
						grp.res[n] = '{UTF8_LEAD2 | {3'b000, v[10:6]}, 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
						grp.res[n] = '{UTF8_CONT | {2'b00, v[5:0]}, 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
					end else begin
						grp.res[n] = '{UTF8_LEAD3 | {4'b0000, v[15:12]}, 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
						grp.res[n] = '{UTF8_CONT | {2'b00, v[11:6]}, 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
						grp.res[n] = '{UTF8_CONT | {2'b00, v[5:0]}, 1'b1, ST_OK, 1'b0};
						n = n + 2'd1;
					end
					mode_d = M_NORMAL;
					hc_d   = 2'd0;
				end
			end
			default: begin
				mode_d = M_NORMAL;
				hc_d   = 2'd0;
			end
		endcase

		if (mode_q != M_DISCARD) begin
			if (err) begin
				mode_d = last_s1 ? M_NORMAL : M_DISCARD;
				hc_d   = 2'd0;
			end else if (last_s1) begin
				if (n == 2'd0) begin
					grp.res[n] = '{8'h00, 1'b0, ST_OK, 1'b1};
					n = n + 2'd1;
				end else begin
					grp.res[n - 2'd1].last = 1'b1;
				end
				mode_d = M_NORMAL;
				hc_d   = 2'd0;
			end
		end
		grp.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			hc_q   <= 2'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			hc_q   <= hc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && held_we) begin
			case (hc_q)
				2'd0:    held_q[0] <= byte_s1;
				2'd1:    held_q[1] <= byte_s1;
				default: held_q[2] <= byte_s1;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/jsu_res_fifo.sv]
// Result queue: takes a group of up to three results, hands out one per transfer.
`default_nettype none
module jsu_res_fifo
	import jsu_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  group_t              grp,
	input  wire logic           pop,
	output result_t             head,
	output logic                not_empty,
	output logic                can_push,
	output logic [FIFO_AW:0]    level
);

	result_t              mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0]   wp_q, rp_q;
	logic [FIFO_AW:0]     cnt_q;
	logic [FIFO_AW:0]     after_pop;

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rp_q];
	assign level     = cnt_q;
	assign after_pop = cnt_q - {{FIFO_AW{1'b0}}, pop};
	assign can_push  = (after_pop <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));

	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < MAX_RES; k++) begin
				if (k < int'(grp.cnt)) begin
					mem_q[wp_q + FIFO_AW'(k)] <= grp.res[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FIFO_AW'(grp.cnt);
			end
			if (pop) begin
				rp_q <= rp_q + FIFO_AW'(1);
			end
			cnt_q <= after_pop + (push ? (FIFO_AW+1)'(grp.cnt) : '0);
		end
	end

endmodule
`default_nettype wire
